// ----- sv/cmfuv_pkg.sv -----
// Shared types and default sizes for the cube map face and UV unit.
package cmfuv_pkg;

    localparam int CMFUV_COMP_WIDTH = 16;
    localparam int CMFUV_FRAC_BITS  = 16;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    typedef struct packed {
        t_face face;
        logic  degenerate;
    } t_tag;

endpackage

// ----- sv/cmfuv_front.sv -----
// Front pipeline: magnitudes, major axis and face select, offset add, integer quotient step.
module cmfuv_front #(
    parameter int COMP_WIDTH = cmfuv_pkg::CMFUV_COMP_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COMP_WIDTH-1:0] i_dir_x,
    input  logic signed [COMP_WIDTH-1:0] i_dir_y,
    input  logic signed [COMP_WIDTH-1:0] i_dir_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output cmfuv_pkg::t_tag              o_tag,
    output logic [COMP_WIDTH-1:0]        o_major,
    output logic [COMP_WIDTH-1:0]        o_rem_u,
    output logic [COMP_WIDTH-1:0]        o_rem_v,
    output logic [1:0]                   o_quo_u,
    output logic [1:0]                   o_quo_v
);
    import cmfuv_pkg::*;

    localparam int W = COMP_WIDTH;

    // integer part of (n / m) with n <= 2m, and the remainder
    function automatic logic [W+1:0] int_step(input logic [W:0] n, input logic [W-1:0] m);
        logic [W:0] m1;
        logic [W:0] m2;
        logic [W:0] d;
        logic [1:0] q;
        m1 = {1'b0, m};
        m2 = {m, 1'b0};
        if (n >= m2) begin
            d = n - m2;
            q = 2'd2;
        end else if (n >= m1) begin
            d = n - m1;
            q = 2'd1;
        end else begin
            d = n;
            q = 2'd0;
        end
        return {q, d[W-1:0]};
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: magnitudes
    logic signed [W-1:0] r1_x, r1_y, r1_z;
    logic [W-1:0]        r1_ax, r1_ay, r1_az;
    logic [W-1:0]        n1_ax, n1_ay, n1_az;

    always_comb begin
        n1_ax = i_dir_x[W-1] ? ($unsigned(~i_dir_x) + 1'b1) : $unsigned(i_dir_x);
        n1_ay = i_dir_y[W-1] ? ($unsigned(~i_dir_y) + 1'b1) : $unsigned(i_dir_y);
        n1_az = i_dir_z[W-1] ? ($unsigned(~i_dir_z) + 1'b1) : $unsigned(i_dir_z);
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_x  <= i_dir_x;
            r1_y  <= i_dir_y;
            r1_z  <= i_dir_z;
            r1_ax <= n1_ax;
            r1_ay <= n1_ay;
            r1_az <= n1_az;
        end
    end

    // stage 2: face select; earlier tests win, so -Z is checked first and Z takes ties over Y and X
    logic              xp, yp, zp, xm, ym, zm;
    logic signed [W:0] sx, sy, sz;
    t_face             n2_face;
    logic [W-1:0]      n2_major;
    logic signed [W:0] n2_uc, n2_vc;
    t_face             r2_face;
    logic [W-1:0]      r2_major;
    logic signed [W:0] r2_uc, r2_vc;

    always_comb begin
        xp = !r1_x[W-1] && (r1_x != '0);
        yp = !r1_y[W-1] && (r1_y != '0);
        zp = !r1_z[W-1] && (r1_z != '0);
        xm = (r1_ax >= r1_ay) && (r1_ax >= r1_az);
        ym = (r1_ay >= r1_ax) && (r1_ay >= r1_az);
        zm = (r1_az >= r1_ax) && (r1_az >= r1_ay);
        sx = {r1_x[W-1], r1_x};
        sy = {r1_y[W-1], r1_y};
        sz = {r1_z[W-1], r1_z};
        priority if (!zp && zm) begin
            n2_face = FACE_NEG_Z; n2_major = r1_az; n2_uc = -sx; n2_vc = sy;
        end else if (zp && zm) begin
            n2_face = FACE_POS_Z; n2_major = r1_az; n2_uc = sx;  n2_vc = sy;
        end else if (!yp && ym) begin
            n2_face = FACE_NEG_Y; n2_major = r1_ay; n2_uc = sx;  n2_vc = sz;
        end else if (yp && ym) begin
            n2_face = FACE_POS_Y; n2_major = r1_ay; n2_uc = sx;  n2_vc = -sz;
        end else if (!xp) begin
            n2_face = FACE_NEG_X; n2_major = r1_ax; n2_uc = sz;  n2_vc = sy;
        end else begin
            n2_face = FACE_POS_X; n2_major = r1_ax; n2_uc = -sz; n2_vc = sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r2_face  <= n2_face;
            r2_major <= n2_major;
            r2_uc    <= n2_uc;
            r2_vc    <= n2_vc;
        end
    end

    // stage 3: shift the in-face components into 0..2*major
    logic [W+1:0] sum_u, sum_v;
    t_tag         r3_tag;
    logic [W-1:0] r3_major;
    logic [W:0]   r3_nu, r3_nv;

    assign sum_u = {r2_uc[W], r2_uc} + {2'b00, r2_major};
    assign sum_v = {r2_vc[W], r2_vc} + {2'b00, r2_major};

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r3_tag.face       <= r2_face;
            r3_tag.degenerate <= (r2_major == '0);
            r3_major          <= r2_major;
            r3_nu             <= sum_u[W:0];
            r3_nv             <= sum_v[W:0];
        end
    end

    // stage 4: integer quotient bits
    logic [W+1:0] step_u, step_v;

    assign step_u = int_step(r3_nu, r3_major);
    assign step_v = int_step(r3_nv, r3_major);

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            o_tag   <= r3_tag;
            o_major <= r3_major;
            o_quo_u <= step_u[W+1:W];
            o_quo_v <= step_v[W+1:W];
            o_rem_u <= step_u[W-1:0];
            o_rem_v <= step_v[W-1:0];
        end
    end

endmodule

// ----- sv/cmfuv_div_step.sv -----
// One restoring-division stage: one fraction bit for each of the two coordinates.
module cmfuv_div_step #(
    parameter int COMP_WIDTH = cmfuv_pkg::CMFUV_COMP_WIDTH,
    parameter int FRAC_BITS  = cmfuv_pkg::CMFUV_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  cmfuv_pkg::t_tag       i_tag,
    input  logic [COMP_WIDTH-1:0] i_major,
    input  logic [COMP_WIDTH-1:0] i_rem_u,
    input  logic [COMP_WIDTH-1:0] i_rem_v,
    input  logic [FRAC_BITS:0]    i_quo_u,
    input  logic [FRAC_BITS:0]    i_quo_v,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cmfuv_pkg::t_tag       o_tag,
    output logic [COMP_WIDTH-1:0] o_major,
    output logic [COMP_WIDTH-1:0] o_rem_u,
    output logic [COMP_WIDTH-1:0] o_rem_v,
    output logic [FRAC_BITS:0]    o_quo_u,
    output logic [FRAC_BITS:0]    o_quo_v
);
    import cmfuv_pkg::*;

    localparam int W = COMP_WIDTH;

    logic         r_valid;
    logic [W-1:0] sh_u, sh_v;
    logic         bit_u, bit_v;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    // remainder stays below major, so doubling fits in W bits
    assign sh_u  = {i_rem_u[W-2:0], 1'b0};
    assign sh_v  = {i_rem_v[W-2:0], 1'b0};
    assign bit_u = (sh_u >= i_major);
    assign bit_v = (sh_v >= i_major);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            o_tag   <= i_tag;
            o_major <= i_major;
            o_rem_u <= bit_u ? (sh_u - i_major) : sh_u;
            o_rem_v <= bit_v ? (sh_v - i_major) : sh_v;
            o_quo_u <= {i_quo_u[FRAC_BITS-1:0], bit_u};
            o_quo_v <= {i_quo_v[FRAC_BITS-1:0], bit_v};
        end
    end

endmodule

// ----- sv/cube_map_face_uv_unit.sv -----
// Top level: cube map face selection and face UV coordinates, fully pipelined.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+----------------------------------------
//  s (in)   | input     | i_s_tvalid / o_s_tready | i_s_tdata: dir_x, dir_y, dir_z
//  m (out)  | output    | o_m_tvalid / i_m_tready | o_m_tdata: face, coord_u, coord_v;
//           |           |                         | o_m_tuser: degenerate
//
// One transfer is accepted every cycle while the output is not stalled. The pipeline
// is four front stages (magnitudes, face select, offset add, integer quotient),
// FRAC_BITS - 2 division stages, and the output stage, which forms the last fraction
// bit. Reset is synchronous and clears only the stage valid bits.
// Each stage holds its item while the next one is full and stalled; empty stages
// keep filling, so the pipeline takes input until every stage holds an item.
module cube_map_face_uv_unit #(
    parameter int COMP_WIDTH = cmfuv_pkg::CMFUV_COMP_WIDTH,
    parameter int FRAC_BITS  = cmfuv_pkg::CMFUV_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // dir_x, dir_y, dir_z, each COMP_WIDTH bits signed, zero pad to bytes on top
    input  logic [((3 * COMP_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // face (3), coord_u (FRAC_BITS+1), coord_v (FRAC_BITS+1), zero pad to bytes on top
    output logic [((3 + 2 * (FRAC_BITS + 1) + 7) / 8) * 8 - 1:0] o_m_tdata,
    // degenerate
    output logic o_m_tuser
);
    import cmfuv_pkg::*;

    localparam int W      = COMP_WIDTH;
    localparam int STEPS  = FRAC_BITS - 2;
    localparam int OUT_W  = ((3 + 2 * (FRAC_BITS + 1) + 7) / 8) * 8;

    // stage links: index 0 is the front output, index STEPS feeds the output stage
    logic               w_valid [0:STEPS];
    logic               w_ready [0:STEPS];
    t_tag               w_tag   [0:STEPS];
    logic [W-1:0]       w_major [0:STEPS];
    logic [W-1:0]       w_rem_u [0:STEPS];
    logic [W-1:0]       w_rem_v [0:STEPS];
    logic [FRAC_BITS:0] w_quo_u [0:STEPS];
    logic [FRAC_BITS:0] w_quo_v [0:STEPS];
    logic [1:0]         front_qu, front_qv;

    cmfuv_front #(
        .COMP_WIDTH(COMP_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_dir_x (i_s_tdata[W-1:0]),
        .i_dir_y (i_s_tdata[2*W-1:W]),
        .i_dir_z (i_s_tdata[3*W-1:2*W]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_tag   (w_tag[0]),
        .o_major (w_major[0]),
        .o_rem_u (w_rem_u[0]),
        .o_rem_v (w_rem_v[0]),
        .o_quo_u (front_qu),
        .o_quo_v (front_qv)
    );

    // integer part lands in the low bits and shifts up as fraction bits arrive
    assign w_quo_u[0] = {{(FRAC_BITS - 1){1'b0}}, front_qu};
    assign w_quo_v[0] = {{(FRAC_BITS - 1){1'b0}}, front_qv};

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        cmfuv_div_step #(
            .COMP_WIDTH(COMP_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_tag   (w_tag[g]),
            .i_major (w_major[g]),
            .i_rem_u (w_rem_u[g]),
            .i_rem_v (w_rem_v[g]),
            .i_quo_u (w_quo_u[g]),
            .i_quo_v (w_quo_v[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_tag   (w_tag[g+1]),
            .o_major (w_major[g+1]),
            .o_rem_u (w_rem_u[g+1]),
            .o_rem_v (w_rem_v[g+1]),
            .o_quo_u (w_quo_u[g+1]),
            .o_quo_v (w_quo_v[g+1])
        );
    end

    // output stage: last fraction bit, zero the coordinates of a degenerate vector
    logic               r_out_valid;
    t_face              r_face;
    logic               r_degen;
    logic [FRAC_BITS:0] r_u, r_v;
    logic [W-1:0]       sh_u, sh_v;
    logic               bit_u, bit_v;
    logic [FRAC_BITS:0] n_u, n_v;

    assign w_ready[STEPS] = !r_out_valid || i_m_tready;

    always_comb begin
        sh_u  = {w_rem_u[STEPS][W-2:0], 1'b0};
        sh_v  = {w_rem_v[STEPS][W-2:0], 1'b0};
        bit_u = (sh_u >= w_major[STEPS]);
        bit_v = (sh_v >= w_major[STEPS]);
        n_u   = {w_quo_u[STEPS][FRAC_BITS-1:0], bit_u};
        n_v   = {w_quo_v[STEPS][FRAC_BITS-1:0], bit_v};
        if (w_tag[STEPS].degenerate) begin
            n_u = '0;
            n_v = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[STEPS]) begin
            r_out_valid <= w_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[STEPS] && w_valid[STEPS]) begin
            r_face  <= w_tag[STEPS].face;
            r_degen <= w_tag[STEPS].degenerate;
            r_u     <= n_u;
            r_v     <= n_v;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_v, r_u, r_face});
    assign o_m_tuser  = r_degen;

endmodule
